// ===== rtl/msam_pkg.sv =====
// Shared constants and types for the multi-stream audio mixer.
package msam_pkg;

	// Configuration port shape
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// Register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIX_CHANNELS = 2'd0,
		REG_VOLUME_GAIN  = 2'd1,
		REG_BALANCE      = 2'd2
	} reg_idx_t;

	// Fixed-point gain format (Q2.14 volume, Q1.14 balance)
	localparam int GAIN_BITS   = 16;
	localparam int ROUND_SHIFT = 14;
	localparam int UNITY_Q14   = 16384;
	localparam int ROUND_HALF  = UNITY_Q14 / 2;

	// Guard bits of the per-channel accumulators above the sample width
	localparam int SUM_GUARD = 4;

	// Channel-count codes
	localparam logic [1:0] CH_MONO   = 2'd1;
	localparam logic [1:0] CH_STEREO = 2'd2;

	// Reset values of the registers
	localparam logic [1:0]           MIX_RESET = CH_STEREO;
	localparam logic [GAIN_BITS-1:0] VOL_RESET = GAIN_BITS'(UNITY_Q14);

endpackage

// ===== rtl/msam_accum.sv =====
// Per-channel saturating accumulators for the frame sums.
module msam_accum #(
	parameter int SB = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                add,
	input  logic                clear,
	input  logic                stereo_mix,
	input  logic                stereo_in,
	input  logic signed [SB-1:0] s0,
	input  logic signed [SB-1:0] s1,
	output logic signed [SB+msam_pkg::SUM_GUARD-1:0] sum_first_nxt,
	output logic signed [SB+msam_pkg::SUM_GUARD-1:0] sum_second_nxt
);
	import msam_pkg::*;

	localparam int SW = SB + SUM_GUARD;
	localparam logic signed [SW:0] LIM_HI = (SW+1)'((1 << (SW-1)) - 1);
	localparam logic signed [SW:0] LIM_LO = -LIM_HI - (SW+1)'(1);

	logic signed [SW-1:0] sum_first_q;
	logic signed [SW-1:0] sum_second_q;
	logic signed [SW:0]   wide_first;
	logic signed [SW:0]   wide_second;
	logic signed [SB-1:0] s_second;

	// Clamp a grown sum back to the accumulator range
	function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] x);
		logic signed [SW-1:0] r;
		if (x > LIM_HI) begin
			r = SW'(LIM_HI);
		end else if (x < LIM_LO) begin
			r = SW'(LIM_LO);
		end else begin
			r = SW'(x);
		end
		return r;
	endfunction

	// A mono stream feeds its first sample into both channels
	assign s_second    = stereo_in ? s1 : s0;
	assign wide_first  = (SW+1)'(sum_first_q) + (SW+1)'(s0);
	assign wide_second = (SW+1)'(sum_second_q) + (SW+1)'(s_second);

	assign sum_first_nxt  = sat_sum(wide_first);
	assign sum_second_nxt = stereo_mix ? sat_sum(wide_second) : sum_second_q;

	// Sums clear once the frame is handed to the scaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_first_q  <= '0;
			sum_second_q <= '0;
		end else if (add) begin
			if (clear) begin
				sum_first_q  <= '0;
				sum_second_q <= '0;
			end else begin
				sum_first_q  <= sum_first_nxt;
				sum_second_q <= sum_second_nxt;
			end
		end
	end

endmodule

// ===== rtl/msam_smul.sv =====
// Bit-serial shift-and-add multiplier with Q14 round-half-up output.
module msam_smul #(
	parameter int MW = 20,
	parameter int NW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [MW-1:0] mcand,
	input  logic [NW-1:0]       mplier,
	output logic                done,
	output logic signed [MW+NW+1-msam_pkg::ROUND_SHIFT-1:0] result
);
	import msam_pkg::*;

	localparam int PW = MW + NW + 1;
	localparam int RW = PW - ROUND_SHIFT;
	localparam int CW = $clog2(NW + 1);

	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] mc_q;
	logic [NW-1:0]        mp_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// One multiplier bit per cycle; the accumulator starts at the rounding half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q  <= PW'(ROUND_HALF);
				mc_q   <= PW'(mcand);
				mp_q   <= mplier;
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (mp_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mc_q  <= mc_q <<< 1;
				mp_q  <= mp_q >> 1;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	// Arithmetic shift gives floor, so with the preload this is round half up
	assign result = RW'(acc_q >>> ROUND_SHIFT);

endmodule

// ===== rtl/multi_stream_audio_mixer_top.sv =====
// Top level of the multi-stream audio mixer: config, sequencer and output register.
//
// Usage: each input transaction on s_* carries one frame of one source stream;
// s_tlast marks the final stream of a frame. Streams are summed per channel
// (mono streams feed both channels). On the tlast transaction the sums are
// scaled by the volume, saturated to the sample range and, in stereo mode,
// the balance attenuates the opposite channel. One result transaction then
// appears on m_*. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it. A non-final stream item is accepted whenever the block
// is idle. A final item starts a sequence on one bit-serial multiplier (a
// start, a load and 16 bit steps per product): one product in mono, two in
// stereo, three in stereo with non-zero balance, then the output register is
// loaded; s_tready is low during that sequence.
// When the receiver stalls, the result waits in the output register and
// further non-final items are still accepted; a new result waits until the
// register is free. Reset clears the sums and restores stereo mode, unity
// volume and centred balance; no output is pending after reset.
module multi_stream_audio_mixer_top #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [msam_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [msam_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata: sample_first, sample_second, stream_channels (from bit 0 up)
	input  logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,
	// output stream
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata: mixed_first, mixed_second, frame_channels (from bit 0 up)
	output logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0] m_tdata
);
	import msam_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int SW  = SB + SUM_GUARD;
	localparam int TDW = ((2*SB+2+7)/8)*8;
	localparam int RW  = SW + GAIN_BITS + 1 - ROUND_SHIFT;
	localparam logic signed [RW-1:0] SMAX = RW'((1 << (SB-1)) - 1);
	localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);
	localparam logic signed [GAIN_BITS-1:0] BAL_HI = GAIN_BITS'(UNITY_Q14);
	localparam logic signed [GAIN_BITS-1:0] BAL_LO = -BAL_HI;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_BAL,
		ST_EMIT
	} state_t;

	// configuration registers
	logic [1:0]                  mix_q;
	logic [GAIN_BITS-1:0]        vol_q;
	logic signed [GAIN_BITS-1:0] bal_q;

	// sequencer
	state_t               state_q;
	logic                 start_q;
	logic signed [SW-1:0] mcand_q;
	logic [GAIN_BITS-1:0] mplier_q;
	logic signed [SW-1:0] wb_q;
	logic                 stereo_q;
	logic                 bal_b_q;
	logic signed [SB-1:0] a_q;
	logic signed [SB-1:0] b_q;

	// output register
	logic                 m_tvalid_q;
	logic signed [SB-1:0] ma_q;
	logic signed [SB-1:0] mb_q;
	logic [1:0]           fc_q;

	logic                 accept;
	logic                 stereo_mix;
	logic signed [SB-1:0] s0;
	logic signed [SB-1:0] s1;
	logic [1:0]           s_ch;
	logic signed [SW-1:0] sum_first_nxt;
	logic signed [SW-1:0] sum_second_nxt;
	logic                 mul_done;
	logic signed [RW-1:0] mul_res;
	logic signed [SB-1:0] mul_sat;
	logic signed [GAIN_BITS-1:0] bal_c;
	logic signed [GAIN_BITS:0]   f_neg;
	logic signed [GAIN_BITS:0]   f_pos;

	// input unpacking
	assign s0       = s_tdata[SB-1:0];
	assign s1       = s_tdata[2*SB-1:SB];
	assign s_ch     = s_tdata[2*SB+1:2*SB];
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign stereo_mix = mix_q[1];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= MIX_RESET;
			vol_q <= VOL_RESET;
			bal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIX_CHANNELS: mix_q <= cfg_data[1:0];
				REG_VOLUME_GAIN:  vol_q <= cfg_data[GAIN_BITS-1:0];
				REG_BALANCE:      bal_q <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	msam_accum #(.SB(SB)) u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.add            (accept),
		.clear          (s_tlast),
		.stereo_mix     (stereo_mix),
		.stereo_in      (s_ch[1]),
		.s0             (s0),
		.s1             (s1),
		.sum_first_nxt  (sum_first_nxt),
		.sum_second_nxt (sum_second_nxt)
	);

	msam_smul #(.MW(SW), .NW(GAIN_BITS)) u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.mcand  (mcand_q),
		.mplier (mplier_q),
		.done   (mul_done),
		.result (mul_res)
	);

	// saturation of the volume product to the sample range
	always_comb begin
		if (mul_res > SMAX) begin
			mul_sat = SB'(SMAX);
		end else if (mul_res < SMIN) begin
			mul_sat = SB'(SMIN);
		end else begin
			mul_sat = SB'(mul_res);
		end
	end

	// balance clamp and attenuation factors
	always_comb begin
		if (bal_q > BAL_HI) begin
			bal_c = BAL_HI;
		end else if (bal_q < BAL_LO) begin
			bal_c = BAL_LO;
		end else begin
			bal_c = bal_q;
		end
	end
	assign f_neg = (GAIN_BITS+1)'(UNITY_Q14) + (GAIN_BITS+1)'(bal_c);
	assign f_pos = (GAIN_BITS+1)'(UNITY_Q14) - (GAIN_BITS+1)'(bal_c);

	// frame sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			stereo_q   <= 1'b0;
			bal_b_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tlast) begin
						mcand_q  <= sum_first_nxt;
						mplier_q <= vol_q;
						wb_q     <= sum_second_nxt;
						stereo_q <= stereo_mix;
						start_q  <= 1'b1;
						state_q  <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					if (mul_done) begin
						a_q <= mul_sat;
						b_q <= '0;
						if (stereo_q) begin
							mcand_q  <= wb_q;
							mplier_q <= vol_q;
							start_q  <= 1'b1;
							state_q  <= ST_MUL_B;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL_B: begin
					if (mul_done) begin
						b_q <= mul_sat;
						if (bal_c < 0) begin
							mcand_q  <= SW'(mul_sat);
							mplier_q <= f_neg[GAIN_BITS-1:0];
							bal_b_q  <= 1'b1;
							start_q  <= 1'b1;
							state_q  <= ST_MUL_BAL;
						end else if (bal_c > 0) begin
							mcand_q  <= SW'(a_q);
							mplier_q <= f_pos[GAIN_BITS-1:0];
							bal_b_q  <= 1'b0;
							start_q  <= 1'b1;
							state_q  <= ST_MUL_BAL;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL_BAL: begin
					// attenuation never grows the value, so low bits suffice
					if (mul_done) begin
						if (bal_b_q) begin
							b_q <= mul_res[SB-1:0];
						end else begin
							a_q <= mul_res[SB-1:0];
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						ma_q       <= a_q;
						mb_q       <= b_q;
						fc_q       <= stereo_q ? CH_STEREO : CH_MONO;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDW'({fc_q, mb_q, ma_q});

endmodule
